[design/isort_pkg.sv]
// ----------------------------------------------------------------------------
// isort_pkg
// Shared types for the insertion sort engine.
// ----------------------------------------------------------------------------
package isort_pkg;

   // control broadcast from the sequencer to every cell of the chain
   typedef struct packed {
      logic insert;   // load the incoming request value into its sorted place
      logic drain;    // shift the chain one place towards cell 0
   } isort_ctrl_type;

endpackage

[design/isort_if.sv]
// ----------------------------------------------------------------------------
// isort_if
// Valid/ready channels for requests and responses of the sort engine.
// ----------------------------------------------------------------------------
interface isort_req_if #(
   parameter int DATA_WIDTH = 32
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] value;
   logic                         last;

   modport source (output valid, output value, output last, input ready);
   modport sink   (input valid, input value, input last, output ready);
endinterface

interface isort_rsp_if #(
   parameter int DATA_WIDTH = 32
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] sorted_value;
   logic                         final_res;
   logic                         overflow;

   modport source (output valid, output sorted_value, output final_res, output overflow,
                   input ready);
   modport sink   (input valid, input sorted_value, input final_res, input overflow,
                   output ready);
endinterface

[design/isort_cell.sv]
// ----------------------------------------------------------------------------
// isort_cell
// One slot of the sorted chain: compares, takes from its neighbour, holds.
// ----------------------------------------------------------------------------
module isort_cell import isort_pkg::*; #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                         clock,
   input  isort_ctrl_type               ctrl,
   input  logic                         occ,
   input  logic signed [DATA_WIDTH-1:0] new_value,
   input  logic signed [DATA_WIDTH-1:0] left_value,
   input  logic                         left_gt,
   input  logic signed [DATA_WIDTH-1:0] right_value,
   output logic signed [DATA_WIDTH-1:0] value,
   output logic                         gt
);

   logic signed [DATA_WIDTH-1:0] value_ff;
   logic signed [DATA_WIDTH-1:0] value_in;

   // an empty slot behaves as +infinity; equal values stay put (stable order)
   assign gt = !occ || (new_value < value_ff);

   always_comb begin
      value_in = value_ff;
      if (ctrl.drain) begin
         value_in = right_value;
      end else if (ctrl.insert && gt) begin
         value_in = left_gt ? left_value : new_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

[design/insertion_sort_engine_core.sv]
// ----------------------------------------------------------------------------
// insertion_sort_engine_core
// Streams a set of signed values into a chain of sorting cells and drains
// it in ascending order once the last request of the set arrives.
// ----------------------------------------------------------------------------
// Insertion: one request per cycle while not draining; every cell compares in parallel.
// Drain: first response the cycle after the last request, then one per cycle
//   while rsp ready is high; the chain shifts towards cell 0 on each pop.
// A set of N held values blocks requests until all N responses have been popped.
// Reset (synchronous, active high) clears the fill count, drain and drop flags;
//   cell contents are not reset.
module insertion_sort_engine_core import isort_pkg::*; #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input logic        clock,
   input logic        reset,
   isort_req_if.sink   req_chan,
   isort_rsp_if.source rsp_chan
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             drain_ff, drain_in;
   logic             dropped_ff, dropped_in;

   logic             req_fire, rsp_fire, store_full;
   isort_ctrl_type   ctrl;

   logic signed [DATA_WIDTH-1:0] cell_value [DEPTH];
   logic                         cell_gt    [DEPTH];

   assign req_chan.ready = !drain_ff;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_fire       = rsp_chan.valid && rsp_chan.ready;
   assign store_full     = (count_ff == CNT_W'(DEPTH));

   assign ctrl.insert = req_fire && !store_full;
   assign ctrl.drain  = rsp_fire;

   always_comb begin
      count_in   = count_ff;
      drain_in   = drain_ff;
      dropped_in = dropped_ff;
      if (req_fire) begin
         if (store_full) begin
            dropped_in = 1'b1;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
         if (req_chan.last) begin
            drain_in = 1'b1;
         end
      end
      if (rsp_fire) begin
         count_in = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            drain_in   = 1'b0;
            dropped_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         drain_ff   <= 1'b0;
         dropped_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         drain_ff   <= drain_in;
         dropped_ff <= dropped_in;
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [DATA_WIDTH-1:0] left_value, right_value;
      logic                         left_gt;

      if (i == 0) begin : g_head
         assign left_value = req_chan.value;
         assign left_gt    = 1'b0;
      end else begin : g_body
         assign left_value = cell_value[i-1];
         assign left_gt    = cell_gt[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_value = cell_value[i];
      end else begin : g_mid
         assign right_value = cell_value[i+1];
      end

      isort_cell #(
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occ         (count_ff > CNT_W'(i)),
         .new_value   (req_chan.value),
         .left_value  (left_value),
         .left_gt     (left_gt),
         .right_value (right_value),
         .value       (cell_value[i]),
         .gt          (cell_gt[i])
      );
   end

   assign rsp_chan.valid        = drain_ff;
   assign rsp_chan.sorted_value = cell_value[0];
   assign rsp_chan.final_res    = (count_ff == CNT_W'(1));
   assign rsp_chan.overflow     = dropped_ff;

   a_no_overlap : assert property (@(posedge clock) disable iff (reset)
      !(req_chan.ready && rsp_chan.valid))
      else $error("request accepted while draining");

   a_count_range : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("fill count beyond depth");

   a_drain_nonempty : assert property (@(posedge clock) disable iff (reset)
      drain_ff |-> (count_ff != '0))
      else $error("draining an empty chain");

   a_last_starts_drain : assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_chan.last) |=> rsp_chan.valid)
      else $error("last request did not start the drain");

endmodule
